>>> hdl/sckd_pkg.sv
// Package with the types, scan code constants and character tables of the set 1 key decoder.
package sckd_pkg;

   // Widths of the channel fields.
   localparam int CODE_W = 8;
   localparam int CHAR_W = 7;
   localparam int KIND_W = 3;

   // Number of entries in each character table, and the bits that index it.
   localparam int ROM_DEPTH = 58;
   localparam int ROM_IDX_W = $clog2(ROM_DEPTH);

   // Scan codes with a special meaning.
   localparam logic [CODE_W-1:0] SC_PREFIX = 8'hE0;
   localparam logic [CODE_W-1:0] SC_LSHIFT = 8'h2A;
   localparam logic [CODE_W-1:0] SC_RSHIFT = 8'h36;
   localparam logic [CODE_W-1:0] SC_CAPS   = 8'h3A;
   localparam logic [CODE_W-1:0] SC_CTRL   = 8'h1D;
   localparam logic [CODE_W-1:0] SC_ALT    = 8'h38;
   localparam logic [CODE_W-1:0] SC_LEFT   = 8'h4B;
   localparam logic [CODE_W-1:0] SC_RIGHT  = 8'h4D;
   localparam logic [CODE_W-1:0] SC_UP     = 8'h48;
   localparam logic [CODE_W-1:0] SC_DOWN   = 8'h50;

   // Kind of key that one scan code produces.
   typedef enum logic [KIND_W-1:0] {
      KIND_NONE  = 3'd0,
      KIND_CHAR  = 3'd1,
      KIND_LEFT  = 3'd2,
      KIND_RIGHT = 3'd3,
      KIND_UP    = 3'd4,
      KIND_DOWN  = 3'd5
   } key_kind_type;

   // Decoder state: the pending prefix and the four modifier flags.
   typedef struct packed {
      logic prefix;
      logic shift;
      logic caps;
      logic ctrl;
      logic alt;
   } dec_state_type;

   // Characters for keys pressed without shift.
   localparam logic [CHAR_W-1:0] ROM_PLAIN [0:ROM_DEPTH-1] = '{
      7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
      7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09, 7'h71, 7'h77, 7'h65, 7'h72,
      7'h74, 7'h79, 7'h75, 7'h69, 7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00,
      7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
      7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E,
      7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A, 7'h00, 7'h20
   };

   // Characters for keys pressed with shift.
   localparam logic [CHAR_W-1:0] ROM_SHIFTED [0:ROM_DEPTH-1] = '{
      7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A,
      7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09, 7'h51, 7'h57, 7'h45, 7'h52,
      7'h54, 7'h59, 7'h55, 7'h49, 7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00,
      7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
      7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4E,
      7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A, 7'h00, 7'h20
   };

   // True for the three rows of letter keys, where caps lock applies.
   function automatic logic is_letter(input logic [CODE_W-1:0] code);
      logic row_q;
      logic row_a;
      logic row_z;
      row_q = (code >= 8'h10) && (code <= 8'h19);
      row_a = (code >= 8'h1E) && (code <= 8'h26);
      row_z = (code >= 8'h2C) && (code <= 8'h32);
      return row_q || row_a || row_z;
   endfunction

endpackage

>>> hdl/sckd_ifs.sv
// Channel interfaces for scan code words in and decoded key words out.

// Scan code channel.
interface sckd_req_if;
   logic                          valid;
   logic                          ready;
   logic [sckd_pkg::CODE_W-1:0]   scan_code;

   modport source (output valid, output scan_code, input ready);
   modport sink   (input valid, input scan_code, output ready);
endinterface

// Decoded key channel.
interface sckd_rsp_if;
   logic                          valid;
   logic                          ready;
   sckd_pkg::key_kind_type        key_kind;
   logic [sckd_pkg::CHAR_W-1:0]   char_code;
   logic                          shift_down;
   logic                          caps_on;
   logic                          ctrl_down;
   logic                          alt_down;

   modport source (output valid, output key_kind, output char_code, output shift_down,
                   output caps_on, output ctrl_down, output alt_down, input ready);
   modport sink   (input valid, input key_kind, input char_code, input shift_down,
                   input caps_on, input ctrl_down, input alt_down, output ready);
endinterface

>>> hdl/sckd_decode.sv
// Combinational decode of one scan code against the current prefix and modifier state.
module sckd_decode (
   input  logic [sckd_pkg::CODE_W-1:0]  code,
   input  sckd_pkg::dec_state_type      state_cur,
   output sckd_pkg::dec_state_type      state_nxt,
   output sckd_pkg::key_kind_type       kind,
   output logic [sckd_pkg::CHAR_W-1:0]  char_code
);

   logic [sckd_pkg::CODE_W-1:0]    key;
   logic [sckd_pkg::ROM_IDX_W-1:0] rom_idx;
   logic                           in_rom;
   logic                           upper;
   logic [sckd_pkg::CHAR_W-1:0]    rom_char;

   // Character table lookup for a plain press; caps lock flips the case of letters only.
   assign key      = {1'b0, code[sckd_pkg::CODE_W-2:0]};
   assign rom_idx  = code[sckd_pkg::ROM_IDX_W-1:0];
   assign in_rom   = (code < 8'(sckd_pkg::ROM_DEPTH));
   assign upper    = state_cur.shift ^ (sckd_pkg::is_letter(code) & state_cur.caps);
   assign rom_char = !in_rom ? '0 :
                     upper   ? sckd_pkg::ROM_SHIFTED[rom_idx] : sckd_pkg::ROM_PLAIN[rom_idx];

   // Prefix, release, extended press and plain press handling.
   always_comb begin
      state_nxt = state_cur;
      kind      = sckd_pkg::KIND_NONE;
      char_code = '0;
      if (code == sckd_pkg::SC_PREFIX) begin
         state_nxt.prefix = 1'b1;
      end else if (code[sckd_pkg::CODE_W-1]) begin
         // A release after a prefix only drops the prefix.
         if (state_cur.prefix) begin
            state_nxt.prefix = 1'b0;
         end else begin
            unique case (key) inside
               sckd_pkg::SC_LSHIFT, sckd_pkg::SC_RSHIFT: state_nxt.shift = 1'b0;
               sckd_pkg::SC_CTRL:                        state_nxt.ctrl  = 1'b0;
               sckd_pkg::SC_ALT:                         state_nxt.alt   = 1'b0;
               default: ;
            endcase
         end
      end else if (state_cur.prefix) begin
         state_nxt.prefix = 1'b0;
         unique case (code)
            sckd_pkg::SC_LEFT:  kind = sckd_pkg::KIND_LEFT;
            sckd_pkg::SC_RIGHT: kind = sckd_pkg::KIND_RIGHT;
            sckd_pkg::SC_UP:    kind = sckd_pkg::KIND_UP;
            sckd_pkg::SC_DOWN:  kind = sckd_pkg::KIND_DOWN;
            sckd_pkg::SC_CTRL:  state_nxt.ctrl = 1'b1;
            sckd_pkg::SC_ALT:   state_nxt.alt  = 1'b1;
            default: ;
         endcase
      end else begin
         unique case (code) inside
            sckd_pkg::SC_LSHIFT, sckd_pkg::SC_RSHIFT: state_nxt.shift = 1'b1;
            sckd_pkg::SC_CAPS:  state_nxt.caps = ~state_cur.caps;
            sckd_pkg::SC_CTRL:  state_nxt.ctrl = 1'b1;
            sckd_pkg::SC_ALT:   state_nxt.alt  = 1'b1;
            default: begin
               char_code = rom_char;
               kind      = (rom_char != '0) ? sckd_pkg::KIND_CHAR : sckd_pkg::KIND_NONE;
            end
         endcase
      end
   end

endmodule

>>> hdl/scancode_set1_key_decoder.sv
// Top level of the set 1 scan code to key decoder.
//
//   Channel  Direction  Word contents
//   req_ch   in         scan_code
//   rsp_ch   out        key_kind, char_code, shift_down, caps_on, ctrl_down, alt_down
//
// One word is taken per cycle while req_ch.ready is high; each scan code word gives exactly one key word.
// A word passes through an input register, then is decoded into the output register.
// Decoder state advances as a word moves from the input register to the output register.
// Reset (synchronous) clears the prefix, all modifier flags and both valid bits.
// A stall on rsp_ch backs up into req_ch only once both registers hold a word.
module scancode_set1_key_decoder (
   input  logic          clock,
   input  logic          reset,
   sckd_req_if.sink      req_ch,
   sckd_rsp_if.source    rsp_ch
);

   logic                          in_valid_ff;
   logic                          in_valid_in;
   logic [sckd_pkg::CODE_W-1:0]   in_code_ff;
   logic                          out_valid_ff;
   logic                          out_valid_in;
   sckd_pkg::key_kind_type        out_kind_ff;
   logic [sckd_pkg::CHAR_W-1:0]   out_char_ff;
   sckd_pkg::dec_state_type       state_ff;
   sckd_pkg::dec_state_type       state_in;
   sckd_pkg::key_kind_type        dec_kind;
   logic [sckd_pkg::CHAR_W-1:0]   dec_char;
   logic                          advance;
   logic                          take_in;

   // Handshake: the input register moves on whenever the output register frees up.
   assign advance      = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;
   assign take_in      = req_ch.valid && req_ch.ready;
   assign in_valid_in  = take_in || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_ch.ready);

   // Decode of the registered scan code.
   sckd_decode u_decode (
      .code      (in_code_ff),
      .state_cur (state_ff),
      .state_nxt (state_in),
      .kind      (dec_kind),
      .char_code (dec_char)
   );

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (take_in) begin
         in_code_ff <= req_ch.scan_code;
      end
      if (advance) begin
         out_kind_ff <= dec_kind;
         out_char_ff <= dec_char;
      end
   end

   // The flags shown are those in force after the word being shown.
   logic shift_out_ff;
   logic caps_out_ff;
   logic ctrl_out_ff;
   logic alt_out_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         shift_out_ff <= state_in.shift;
         caps_out_ff  <= state_in.caps;
         ctrl_out_ff  <= state_in.ctrl;
         alt_out_ff   <= state_in.alt;
      end
   end

   assign rsp_ch.valid      = out_valid_ff;
   assign rsp_ch.key_kind   = out_kind_ff;
   assign rsp_ch.char_code  = out_char_ff;
   assign rsp_ch.shift_down = shift_out_ff;
   assign rsp_ch.caps_on    = caps_out_ff;
   assign rsp_ch.ctrl_down  = ctrl_out_ff;
   assign rsp_ch.alt_down   = alt_out_ff;

   // A character word always carries a nonzero character, and other words carry none.
   a_char_nonzero : assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.key_kind == sckd_pkg::KIND_CHAR) |-> (rsp_ch.char_code != '0))
      else $error("character word with zero character code");

   a_noncHar_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.key_kind != sckd_pkg::KIND_CHAR) |-> (rsp_ch.char_code == '0))
      else $error("non-character word with nonzero character code");

   // Any word other than the prefix consumes a pending prefix.
   a_prefix_clears : assert property (@(posedge clock) disable iff (reset)
      (advance && state_ff.prefix && in_code_ff != sckd_pkg::SC_PREFIX) |=> !state_ff.prefix)
      else $error("prefix survived a following scan code");

   // Caps lock only changes when a word is decoded.
   a_caps_stable : assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(state_ff.caps))
      else $error("caps lock changed without a decoded word");

endmodule

>>> tb/sv/tb_scancode_set1_key_decoder.sv
// Testbench for the set 1 scan code key decoder: random and directed words, self-checking.
`timescale 1ns / 1ps

// Bit that marks a key release in a set 1 scan code.
localparam logic [sckd_pkg::CODE_W-1:0] RELEASE_BIT = 8'h80;

// Character tables used by the scoreboard, indexed by scan code.
localparam logic [sckd_pkg::CHAR_W-1:0] LOWER_CHARS [0:sckd_pkg::ROM_DEPTH-1] = '{
   7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
   7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09, 7'h71, 7'h77, 7'h65, 7'h72,
   7'h74, 7'h79, 7'h75, 7'h69, 7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00,
   7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
   7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E,
   7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A, 7'h00, 7'h20
};

localparam logic [sckd_pkg::CHAR_W-1:0] UPPER_CHARS [0:sckd_pkg::ROM_DEPTH-1] = '{
   7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A,
   7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09, 7'h51, 7'h57, 7'h45, 7'h52,
   7'h54, 7'h59, 7'h55, 7'h49, 7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00,
   7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
   7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4E,
   7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A, 7'h00, 7'h20
};

// One decoded key word as it appears on the result channel.
typedef struct packed {
   sckd_pkg::key_kind_type      kind;
   logic [sckd_pkg::CHAR_W-1:0] ch;
   logic                        shift;
   logic                        caps;
   logic                        ctrl;
   logic                        alt;
} key_word_type;

// Tracks keyboard state and holds the key words still due from the decoder.
class key_decode_scoreboard;
   logic         prefix_pending;
   logic         shift_held;
   logic         caps_latched;
   logic         ctrl_held;
   logic         alt_held;
   key_word_type due_keys[$];
   int           mismatches;

   function new();
      prefix_pending = 1'b0;
      shift_held     = 1'b0;
      caps_latched   = 1'b0;
      ctrl_held      = 1'b0;
      alt_held       = 1'b0;
      mismatches     = 0;
   endfunction

   // Caps lock only affects the three letter rows.
   function logic letter_key(logic [sckd_pkg::CODE_W-1:0] code);
      return (code >= 8'h10 && code <= 8'h19) || (code >= 8'h1E && code <= 8'h26) ||
             (code >= 8'h2C && code <= 8'h32);
   endfunction

   // Advance the keyboard state by one accepted scan code and queue the key word it gives.
   function void note_scan_code(logic [sckd_pkg::CODE_W-1:0] code);
      key_word_type                  want;
      logic [sckd_pkg::CODE_W-1:0]   key;
      logic [sckd_pkg::ROM_IDX_W-1:0] idx;
      logic                          upper;
      want.kind = sckd_pkg::KIND_NONE;
      want.ch   = '0;
      key       = code & ~RELEASE_BIT;
      idx       = code[sckd_pkg::ROM_IDX_W-1:0];
      if (code == sckd_pkg::SC_PREFIX) begin
         prefix_pending = 1'b1;
      end else if (code[sckd_pkg::CODE_W-1]) begin
         // An extended release only ends the prefix; modifiers stay as they are.
         if (prefix_pending) begin
            prefix_pending = 1'b0;
         end else if (key == sckd_pkg::SC_LSHIFT || key == sckd_pkg::SC_RSHIFT) begin
            shift_held = 1'b0;
         end else if (key == sckd_pkg::SC_CTRL) begin
            ctrl_held = 1'b0;
         end else if (key == sckd_pkg::SC_ALT) begin
            alt_held = 1'b0;
         end
      end else if (prefix_pending) begin
         prefix_pending = 1'b0;
         case (code)
            sckd_pkg::SC_LEFT:  want.kind = sckd_pkg::KIND_LEFT;
            sckd_pkg::SC_RIGHT: want.kind = sckd_pkg::KIND_RIGHT;
            sckd_pkg::SC_UP:    want.kind = sckd_pkg::KIND_UP;
            sckd_pkg::SC_DOWN:  want.kind = sckd_pkg::KIND_DOWN;
            sckd_pkg::SC_CTRL:  ctrl_held = 1'b1;
            sckd_pkg::SC_ALT:   alt_held = 1'b1;
            default:  ;
         endcase
      end else begin
         case (code) inside
            sckd_pkg::SC_LSHIFT, sckd_pkg::SC_RSHIFT: shift_held = 1'b1;
            sckd_pkg::SC_CAPS:                        caps_latched = ~caps_latched;
            sckd_pkg::SC_CTRL:                        ctrl_held = 1'b1;
            sckd_pkg::SC_ALT:                         alt_held = 1'b1;
            default: begin
               if (code < sckd_pkg::ROM_DEPTH) begin
                  upper   = shift_held ^ (letter_key(code) & caps_latched);
                  want.ch = upper ? UPPER_CHARS[idx] : LOWER_CHARS[idx];
               end
               if (want.ch != '0) want.kind = sckd_pkg::KIND_CHAR;
            end
         endcase
      end
      want.shift = shift_held;
      want.caps  = caps_latched;
      want.ctrl  = ctrl_held;
      want.alt   = alt_held;
      due_keys.push_back(want);
   endfunction

   function void report(string what, key_word_type want, key_word_type got);
      mismatches++;
      if (mismatches <= 10)
         $display({"%0t: %s: expected kind %0d char %02h s/c/c/a %b%b%b%b, ",
                   "got kind %0d char %02h s/c/c/a %b%b%b%b"},
                  $realtime, what, want.kind, want.ch, want.shift, want.caps, want.ctrl,
                  want.alt, got.kind, got.ch, got.shift, got.caps, got.ctrl, got.alt);
   endfunction

   // Compare one received key word with the oldest one due.
   function void check_key_word(key_word_type got);
      key_word_type want;
      if (due_keys.size() == 0) begin
         report("unexpected key word", '0, got);
      end else begin
         want = due_keys.pop_front();
         if (got.kind !== want.kind || got.ch !== want.ch || got.shift !== want.shift ||
             got.caps !== want.caps || got.ctrl !== want.ctrl || got.alt !== want.alt)
            report("key word mismatch", want, got);
      end
   endfunction

   function int pending();
      return due_keys.size();
   endfunction
endclass

module tb_scancode_set1_key_decoder;

   // Directed opening: unmapped codes, caps and shift on letters, modifier presses and
   // releases, repeated prefix, extended ctrl press and release, other code after prefix.
   localparam int NUM_DIRECTED = 27;
   localparam logic [sckd_pkg::CODE_W-1:0] DIRECTED_CODES [0:NUM_DIRECTED-1] = '{
      8'h00, 8'hFF, 8'h39, 8'h10, sckd_pkg::SC_CAPS, 8'h10, sckd_pkg::SC_LSHIFT, 8'h10,
      8'h02, sckd_pkg::SC_LSHIFT | RELEASE_BIT, sckd_pkg::SC_RSHIFT,
      sckd_pkg::SC_RSHIFT | RELEASE_BIT,
      sckd_pkg::SC_CTRL, sckd_pkg::SC_CTRL | RELEASE_BIT,
      sckd_pkg::SC_ALT, sckd_pkg::SC_ALT | RELEASE_BIT,
      sckd_pkg::SC_PREFIX, sckd_pkg::SC_PREFIX, sckd_pkg::SC_LEFT, sckd_pkg::SC_PREFIX,
      sckd_pkg::SC_CTRL, sckd_pkg::SC_PREFIX,
      sckd_pkg::SC_CTRL | RELEASE_BIT, sckd_pkg::SC_CTRL | RELEASE_BIT,
      sckd_pkg::SC_PREFIX, 8'h10, sckd_pkg::SC_CAPS
   };
   localparam logic [sckd_pkg::CODE_W-1:0] MODIFIER_CODES [0:4] = '{
      sckd_pkg::SC_LSHIFT, sckd_pkg::SC_RSHIFT, sckd_pkg::SC_CAPS, sckd_pkg::SC_CTRL,
      sckd_pkg::SC_ALT
   };
   localparam logic [sckd_pkg::CODE_W-1:0] EXTENDED_CODES [0:7] = '{
      sckd_pkg::SC_LEFT, sckd_pkg::SC_RIGHT, sckd_pkg::SC_UP, sckd_pkg::SC_DOWN,
      sckd_pkg::SC_CTRL, sckd_pkg::SC_ALT,
      sckd_pkg::SC_CTRL | RELEASE_BIT, sckd_pkg::SC_ALT | RELEASE_BIT
   };

   logic clock;
   logic reset;
   int   send_idle_pct;
   int   recv_idle_pct;
   int   words_sent;

   key_decode_scoreboard sb;

   sckd_req_if req_ch ();
   sckd_rsp_if rsp_ch ();

   scancode_set1_key_decoder uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   // Offer one scan code word, with random idle cycles ahead of it.
   task automatic send_code(input logic [sckd_pkg::CODE_W-1:0] code);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.scan_code <= code;
      do @(posedge clock); while (!req_ch.ready);
      sb.note_scan_code(code);
      words_sent++;
   endtask

   // Mostly well-formed key sequences, with some raw noise bytes.
   task automatic send_random_sequence();
      int                          pick;
      logic [sckd_pkg::CODE_W-1:0] code;
      pick = $urandom_range(99);
      if (pick < 40) begin
         code = sckd_pkg::CODE_W'($urandom_range(8'h39));
         send_code(code);
         if ($urandom_range(1)) send_code(code | RELEASE_BIT);
      end else if (pick < 52) begin
         send_code(MODIFIER_CODES[3'($urandom_range(4))]);
      end else if (pick < 62) begin
         send_code(MODIFIER_CODES[3'($urandom_range(4))] | RELEASE_BIT);
      end else if (pick < 82) begin
         send_code(sckd_pkg::SC_PREFIX);
         send_code(EXTENDED_CODES[3'($urandom_range(7))]);
      end else if (pick < 90) begin
         send_code(sckd_pkg::SC_PREFIX);
         send_code(sckd_pkg::CODE_W'($urandom_range(255)));
      end else begin
         send_code(sckd_pkg::CODE_W'($urandom_range(255)));
      end
   endtask

   // Receiver: check each accepted key word, then pick ready for the next edge.
   always @(posedge clock) begin
      key_word_type got;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got.kind  = rsp_ch.key_kind;
         got.ch    = rsp_ch.char_code;
         got.shift = rsp_ch.shift_down;
         got.caps  = rsp_ch.caps_on;
         got.ctrl  = rsp_ch.ctrl_down;
         got.alt   = rsp_ch.alt_down;
         sb.check_key_word(got);
      end
      rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Main sequence: reset, directed words, then three random phases with different idle settings.
   initial begin
      sb               = new();
      reset            = 1'b1;
      req_ch.valid     = 1'b0;
      req_ch.scan_code = '0;
      rsp_ch.ready     = 1'b0;
      send_idle_pct    = 28;
      recv_idle_pct    = 72;
      words_sent       = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      for (int i = 0; i < NUM_DIRECTED; i++) send_code(DIRECTED_CODES[5'(i)]);
      while (words_sent < 530) send_random_sequence();
      send_idle_pct = 72;
      recv_idle_pct = 28;
      while (words_sent < 1070) send_random_sequence();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      while (words_sent < 1600) send_random_sequence();
      req_ch.valid <= 1'b0;

      // Drain, then wait for any stray key word to show up.
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (sb.mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #500000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
